@@ rtl/core/bmprle_pkg.sv @@
package bmprle_pkg;

  localparam int QueueDepth = 4;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [1:0] CMD_PALETTE = 2'd0;
  localparam logic [1:0] CMD_DATA    = 2'd1;
  localparam logic [1:0] CMD_BEGIN   = 2'd2;

  localparam logic [1:0] KIND_FILL   = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_FORMAT  = 2'd2;

  localparam logic [4:0] Mask5 = 5'h1f;
  localparam logic [5:0] Mask6 = 6'h3f;

  // One word handed from the parser to the palette side.
  typedef struct packed {
    logic        wr;
    logic [7:0]  idx;
    logic [31:0] data;
    logic [1:0]  kind;
    logic [22:0] offset;
    logic [7:0]  len;
  } op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [22:0] offset;
    logic [7:0]  len;
    logic [31:0] value;
  } res_t;

  function automatic logic [31:0] to_rgb565(input logic [31:0] w);
    logic [4:0] b;
    logic [5:0] g;
    logic [4:0] r;
    b = w[7:3] & Mask5;
    g = w[15:10] & Mask6;
    r = w[23:19] & Mask5;
    return {16'd0, r, g, b};
  endfunction

endpackage

@@ rtl/core/bmprle_ram.sv @@
module bmprle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/core/bmprle_fifo.sv @@
module bmprle_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = slot_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/core/bmprle_front.sv @@
module bmprle_front
  import bmprle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  palette_index_i,
  input  logic [31:0] palette_word_i,
  input  logic [7:0]  data_byte_i,
  input  logic [11:0] width_i,
  input  logic [11:0] height_i,
  input  logic        format_i,
  output logic        op_valid_o,
  output op_t         op_o
);

  localparam logic [2:0] PH_COUNT = 3'd0;
  localparam logic [2:0] PH_COLOR = 3'd1;
  localparam logic [2:0] PH_ESC   = 3'd2;
  localparam logic [2:0] PH_DX    = 3'd3;
  localparam logic [2:0] PH_DY    = 3'd4;
  localparam logic [2:0] PH_ABS   = 3'd5;
  localparam logic [2:0] PH_PAD   = 3'd6;
  localparam logic [2:0] PH_DONE  = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  run_left_q, run_left_d;
  logic [21:0] row_start_q, row_start_d;
  logic [22:0] line_pos_q, line_pos_d;
  logic [12:0] rows_left_q, rows_left_d;
  logic        pad_q, pad_d;

  logic [11:0] height_m1;
  logic [23:0] begin_prod;
  logic [19:0] drop;
  logic [7:0]  run_next;
  logic        op_valid;

  assign height_m1  = height_i - 12'd1;
  assign begin_prod = {12'd0, height_m1} * {12'd0, width_i};
  assign drop       = {12'd0, data_byte_i} * {8'd0, width_i};
  assign run_next   = (run_left_q != 8'd0) ? run_left_q - 8'd1 : 8'd0;

  always_comb begin
    phase_d     = phase_q;
    run_left_d  = run_left_q;
    row_start_d = row_start_q;
    line_pos_d  = line_pos_q;
    rows_left_d = rows_left_q;
    pad_d       = pad_q;
    op_valid    = 1'b0;
    op_o        = '0;
    op_o.kind   = KIND_FILL;
    op_o.idx    = data_byte_i;

    case (cmd_i)
      CMD_PALETTE: begin
        op_valid = 1'b1;
        op_o.wr  = 1'b1;
        op_o.idx = palette_index_i;
        op_o.data = format_i ? to_rgb565(palette_word_i) : palette_word_i;
      end
      CMD_BEGIN: begin
        row_start_d = begin_prod[21:0];
        line_pos_d  = {1'b0, begin_prod[21:0]};
        rows_left_d = {1'b0, height_i};
        phase_d     = PH_COUNT;
        run_left_d  = 8'd0;
        pad_d       = 1'b0;
      end
      CMD_DATA: begin
        case (phase_q)
          PH_COUNT: begin
            if (data_byte_i != 8'd0) begin
              run_left_d = data_byte_i;
              phase_d    = PH_COLOR;
            end else begin
              phase_d = PH_ESC;
            end
          end
          PH_COLOR: begin
            op_valid    = 1'b1;
            op_o.offset = line_pos_q;
            op_o.len    = run_left_q;
            line_pos_d  = line_pos_q + {15'd0, run_left_q};
            run_left_d  = 8'd0;
            phase_d     = PH_COUNT;
          end
          PH_ESC: begin
            if (data_byte_i == 8'd0) begin
              if (rows_left_q <= 13'd1) begin
                rows_left_d = 13'd0;
                phase_d     = PH_DONE;
                op_valid    = 1'b1;
                op_o.kind   = KIND_DONE;
              end else begin
                rows_left_d = rows_left_q - 13'd1;
                row_start_d = (row_start_q >= {10'd0, width_i}) ?
                              row_start_q - {10'd0, width_i} : 22'd0;
                line_pos_d  = {1'b0, row_start_d};
                phase_d     = PH_COUNT;
              end
            end else if (data_byte_i == 8'd1) begin
              phase_d   = PH_DONE;
              op_valid  = 1'b1;
              op_o.kind = KIND_DONE;
            end else if (data_byte_i == 8'd2) begin
              phase_d = PH_DX;
            end else begin
              run_left_d = data_byte_i;
              pad_d      = data_byte_i[0];
              phase_d    = PH_ABS;
            end
          end
          PH_DX: begin
            // The horizontal step is applied here; nothing else moves the position before dy.
            line_pos_d = line_pos_q + {15'd0, data_byte_i};
            phase_d    = PH_DY;
          end
          PH_DY: begin
            if (({2'd0, drop} > row_start_q) || ({3'd0, drop} > line_pos_q)) begin
              phase_d   = PH_DONE;
              op_valid  = 1'b1;
              op_o.kind = KIND_ERROR;
            end else begin
              row_start_d = row_start_q - {2'd0, drop};
              line_pos_d  = line_pos_q - {3'd0, drop};
              rows_left_d = (rows_left_q > {5'd0, data_byte_i}) ?
                            rows_left_q - {5'd0, data_byte_i} : 13'd0;
              phase_d     = PH_COUNT;
            end
          end
          PH_ABS: begin
            op_valid    = 1'b1;
            op_o.offset = line_pos_q;
            op_o.len    = 8'd1;
            line_pos_d  = line_pos_q + 23'd1;
            run_left_d  = run_next;
            if (run_next == 8'd0) begin
              phase_d = pad_q ? PH_PAD : PH_COUNT;
              pad_d   = 1'b0;
            end
          end
          PH_PAD: begin
            phase_d = PH_COUNT;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign op_valid_o = accept_i & op_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_COUNT;
      run_left_q  <= '0;
      row_start_q <= '0;
      line_pos_q  <= '0;
      rows_left_q <= '0;
      pad_q       <= 1'b0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      run_left_q  <= run_left_d;
      row_start_q <= row_start_d;
      line_pos_q  <= line_pos_d;
      rows_left_q <= rows_left_d;
      pad_q       <= pad_d;
    end
  end

endmodule

@@ rtl/core/bmprle_back.sv @@
module bmprle_back
  import bmprle_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  op_t                  op_i,
  input  logic                 op_empty_i,
  output logic                 op_pop_o,
  input  logic [QueueCntW-1:0] res_count_i,
  output logic                 res_push_o,
  output res_t                 res_o
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic       in_range;
  logic       credit;
  logic       issue;
  logic       s2_valid_q;
  logic       s2_zero_q;
  logic [1:0] s2_kind_q;
  logic [22:0] s2_offset_q;
  logic [7:0]  s2_len_q;
  logic [31:0] rdata;

  assign in_range = ({1'b0, op_i.idx} < 9'(PALETTE_DEPTH));
  // Results in flight never exceed the free room of the result queue.
  assign credit   = ({1'b0, res_count_i} + {{QueueCntW{1'b0}}, s2_valid_q})
                    < (QueueCntW + 1)'(QueueDepth);
  assign issue    = ~op_empty_i & (op_i.wr | credit);
  assign op_pop_o = issue;

  bmprle_ram #(
    .WIDTH(32),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (issue & op_i.wr & in_range),
    .waddr_i(op_i.idx[AW-1:0]),
    .wdata_i(op_i.data),
    .raddr_i(op_i.idx[AW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= issue & ~op_i.wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_zero_q   <= (op_i.kind != KIND_FILL) | ~in_range;
      s2_kind_q   <= op_i.kind;
      s2_offset_q <= op_i.offset;
      s2_len_q    <= op_i.len;
    end
  end

  assign res_push_o   = s2_valid_q;
  assign res_o.kind   = s2_kind_q;
  assign res_o.offset = s2_offset_q;
  assign res_o.len    = s2_len_q;
  assign res_o.value  = s2_zero_q ? 32'd0 : rdata;

endmodule

@@ rtl/core/bmp_rle8_palette_decoder_unit.sv @@
// Channel   Handshake                Payload
// input     push / full              cmd_i, palette_index_i, palette_word_i, data_byte_i
// result    empty / pop              kind_o, pixel_offset_o, run_length_o, pixel_value_o
// config    cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_wdata_i
//
// One word is taken per cycle while full is low; the parser decides its effect in the cycle it is taken.
// A result passes through the parser queue, the palette read register and the result queue to reach the result ports.
// The palette side takes one word per cycle from the parser queue; a read waits while the result queue has no room.
// Reset clears parser state and both queues; the palette holds no value until written.
// A full parser queue raises full; a stalled result side fills the result queue first.
module bmp_rle8_palette_decoder_unit
  import bmprle_pkg::*;
#(
  parameter int MAX_WIDTH     = 2048,
  parameter int MAX_HEIGHT    = 2048,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  palette_index_i,
  input  logic [31:0] palette_word_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [22:0] pixel_offset_o,
  output logic [7:0]  run_length_o,
  output logic [31:0] pixel_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_wdata_i
);

  localparam logic [11:0] WidthRst  = (MAX_WIDTH < 640) ? 12'(MAX_WIDTH) : 12'd640;
  localparam logic [11:0] HeightRst = (MAX_HEIGHT < 480) ? 12'(MAX_HEIGHT) : 12'd480;

  function automatic logic [11:0] clamp_dim(input logic [11:0] v, input int max);
    logic [11:0] r;
    r = v;
    if (v == 12'd0) begin
      r = 12'd1;
    end else if ({2'b00, v} > 14'(max)) begin
      r = 12'(max);
    end
    return r;
  endfunction

  logic [11:0] width_q, height_q;
  logic        format_q;
  logic        cfg_we;
  logic        accept;
  logic        op_valid;
  op_t         op_in, op_head;
  logic        op_empty, op_pop;
  logic        res_push;
  res_t        res_in, res_head;
  logic [QueueCntW-1:0] res_count;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign accept      = push & ~full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      format_q <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= clamp_dim(cfg_wdata_i, MAX_WIDTH);
        REG_HEIGHT: height_q <= clamp_dim(cfg_wdata_i, MAX_HEIGHT);
        REG_FORMAT: format_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  bmprle_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .cmd_i          (cmd_i),
    .palette_index_i(palette_index_i),
    .palette_word_i (palette_word_i),
    .data_byte_i    (data_byte_i),
    .width_i        (width_q),
    .height_i       (height_q),
    .format_i       (format_q),
    .op_valid_o     (op_valid),
    .op_o           (op_in)
  );

  bmprle_fifo #(
    .WIDTH($bits(op_t)),
    .DEPTH(QueueDepth)
  ) u_op_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (op_valid),
    .wdata_i(op_in),
    .pop_i  (op_pop),
    .rdata_o(op_head),
    .full_o (full),
    .empty_o(op_empty),
    .count_o()
  );

  bmprle_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op_head),
    .op_empty_i (op_empty),
    .op_pop_o   (op_pop),
    .res_count_i(res_count),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  bmprle_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(QueueDepth)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .pop_i  (pop),
    .rdata_o(res_head),
    .full_o (),
    .empty_o(empty),
    .count_o(res_count)
  );

  assign kind_o         = res_head.kind;
  assign pixel_offset_o = res_head.offset;
  assign run_length_o   = res_head.len;
  assign pixel_value_o  = res_head.value;

endmodule
